>>> rtl/core/byte_translate_map_macros.svh
// Assertion macros for the byte translation map checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BYTE_TRANSLATE_MAP_MACROS_SVH
`define BYTE_TRANSLATE_MAP_MACROS_SVH

// Same-cycle implication.
`define BTM_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/btm_pkg.sv
// Shared types and constants for the byte translation map.
// No dependencies.
package btm_pkg;

  localparam int CharW   = 8;
  localparam int MapDepth = 256;
  localparam int ActW    = CharW + 1;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_MAP   = 2'd1;
  localparam logic [1:0] REQ_TEXT  = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'b001,
    OP_MAP   = 3'b010,
    OP_TEXT  = 3'b100
  } btm_op_e;

  typedef struct packed {
    btm_op_e          op;
    logic [CharW-1:0] ch;
    logic [CharW-1:0] repl;
    logic             has_repl;
    logic             last;
  } btm_item_t;

  typedef struct packed {
    logic      push;
    btm_item_t item;
  } btm_push_t;

endpackage

>>> rtl/core/btm_front.sv
// Front end: accepts requests and classifies them into queue items.
// Depends on btm_pkg.
module btm_front (
  input  logic                     start_i,
  input  logic                     full_i,
  input  logic [1:0]               req_type_i,
  input  logic [btm_pkg::CharW-1:0] char_in_i,
  input  logic [btm_pkg::CharW-1:0] replacement_i,
  input  logic                     has_replacement_i,
  input  logic                     last_in_i,
  output logic                     busy_o,
  output btm_pkg::btm_push_t       push_o
);
  import btm_pkg::*;

  logic accept;
  logic known;

  assign busy_o = full_i;
  assign accept = start_i && !full_i;

  always_comb begin
    known               = 1'b1;
    push_o.item.op      = OP_TEXT;
    push_o.item.ch      = char_in_i;
    push_o.item.repl    = replacement_i;
    push_o.item.has_repl = has_replacement_i;
    push_o.item.last    = last_in_i;
    unique case (req_type_i)
      REQ_CLEAR: push_o.item.op = OP_CLEAR;
      REQ_MAP:   push_o.item.op = OP_MAP;
      REQ_TEXT:  push_o.item.op = OP_TEXT;
      default:   known = 1'b0;  // drop the unused code
    endcase
    push_o.push = accept && known;
  end

endmodule

>>> rtl/core/btm_queue.sv
// Short in-order queue between front and back end.
// Depends on btm_pkg.
module btm_queue #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btm_pkg::btm_push_t push_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output btm_pkg::btm_item_t head_o
);
  import btm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  btm_item_t       slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    case ({push_i.push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      slot_q[wr_q] <= push_i.item;
    end
  end

endmodule

>>> rtl/core/btm_back.sv
// Back end: map table, clear, first-wins mapping writes and text lookup.
// Depends on btm_pkg.
module btm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  btm_pkg::btm_item_t        head_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic [btm_pkg::CharW-1:0] out_char_o,
  output logic                      kept_o,
  output logic                      last_out_o
);
  import btm_pkg::*;

  logic [MapDepth-1:0] set_q, set_d;
  logic [ActW-1:0]     act_mem [MapDepth];
  logic [ActW-1:0]     act_rd_q;
  logic                wr_en;
  logic                rd_en;

  logic                done_q;
  logic                hit_q;
  logic [CharW-1:0]    ch_q;
  logic                last_q;

  assign pop_o = !empty_i;
  assign wr_en = pop_o && (head_i.op == OP_MAP) && !set_q[head_i.ch];
  assign rd_en = pop_o && (head_i.op == OP_TEXT);

  always_comb begin
    set_d = set_q;
    if (pop_o && (head_i.op == OP_CLEAR)) begin
      set_d = '0;
    end else if (wr_en) begin
      set_d[head_i.ch] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q  <= '0;
      done_q <= 1'b0;
    end else begin
      set_q  <= set_d;
      done_q <= rd_en;
    end
  end

  // Table and text payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      act_mem[head_i.ch] <= {head_i.has_repl, head_i.repl};
    end
    if (rd_en) begin
      act_rd_q <= act_mem[head_i.ch];
      hit_q    <= set_q[head_i.ch];
      ch_q     <= head_i.ch;
      last_q   <= head_i.last;
    end
  end

  always_comb begin
    kept_o     = 1'b1;
    out_char_o = ch_q;
    if (hit_q) begin
      kept_o     = act_rd_q[ActW-1];
      out_char_o = act_rd_q[ActW-1] ? act_rd_q[CharW-1:0] : '0;
    end
  end

  assign done_o     = done_q;
  assign last_out_o = last_q;

endmodule

>>> rtl/core/byte_translate_map.sv
// Byte translation map, top level.
// Path: an accepted text byte is written into a queue slot, read at the queue head by the
// back end, and its lookup result is registered and shown on the outputs with done_o.
// Throughput: one request per cycle while busy is low; the back end retires one queue
// item per cycle, bound by the single read/write port of the action table.
// Reset: asynchronous; the map comes up as identity, no clearing pass, and the
// result strobe is unconditional, the receiver cannot stall it.
module byte_translate_map #(
  parameter int QueueDepth = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                req_type_i,
  input  logic [btm_pkg::CharW-1:0] char_in_i,
  input  logic [btm_pkg::CharW-1:0] replacement_i,
  input  logic                      has_replacement_i,
  input  logic                      last_in_i,
  output logic                      done_o,
  output logic [btm_pkg::CharW-1:0] out_char_o,
  output logic                      kept_o,
  output logic                      last_out_o
);
  import btm_pkg::*;

  btm_push_t push;
  btm_item_t head;
  logic      full;
  logic      empty;
  logic      pop;

  // Classify each transfer; clear, map and text items go on, code 3 is dropped.
  btm_front u_front (
    .start_i           (start),
    .full_i            (full),
    .req_type_i        (req_type_i),
    .char_in_i         (char_in_i),
    .replacement_i     (replacement_i),
    .has_replacement_i (has_replacement_i),
    .last_in_i         (last_in_i),
    .busy_o            (busy),
    .push_o            (push)
  );

  // Hold items in order until the back end takes them.
  btm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Carry out items: clear the valid bits, write first mapping only, look up text.
  btm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .done_o     (done_o),
    .out_char_o (out_char_o),
    .kept_o     (kept_o),
    .last_out_o (last_out_o)
  );

endmodule

>>> rtl/core/btm_checker.sv
// Port-level checker for the byte translation map, bound to the top level.
// Depends on btm_pkg and byte_translate_map_macros.svh.
`include "byte_translate_map_macros.svh"

module btm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                req_type_i,
  input logic                      done_o,
  input logic [btm_pkg::CharW-1:0] out_char_o,
  input logic                      kept_o
);
  import btm_pkg::*;

  logic [3:0] pend_q;
  logic       text_acc;

  assign text_acc = start && !busy && (req_type_i == REQ_TEXT);

  // Count text transfers whose result is still owed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      case ({text_acc, done_o})
        2'b10:   pend_q <= pend_q + 4'd1;
        2'b01:   pend_q <= pend_q - 4'd1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  `BTM_ASSERT_NOW(a_deleted_zero, done_o && !kept_o, out_char_o == '0, "deleted byte not zero")
  `BTM_ASSERT_NOW(a_no_spurious, done_o, pend_q != 4'd0, "result without text transfer")
  `BTM_ASSERT_NEXT(a_drain, busy, !busy, "busy held two cycles")

endmodule

bind byte_translate_map btm_checker u_btm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .req_type_i (req_type_i),
  .done_o     (done_o),
  .out_char_o (out_char_o),
  .kept_o     (kept_o)
);

>>> dv/byte_translate_map_tb.sv
// Self-checking testbench for byte_translate_map: clears, mappings and text transfers
// are predicted in a local translation table and compared with each result strobe.
// Depends on btm_pkg and the byte_translate_map RTL.
module byte_translate_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btm_pkg::*;

  // Request code 3 is not decoded by the block; it must leave the map alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int StallLimit  = 500;  // cycles without any transfer before giving up
  localparam int TailCycles  = 8;    // settle time after the last expected result
  localparam int TextTarget  = 600;  // decoded requests to generate
  localparam int QuietTail   = 100;  // last requests go out back to back

  typedef struct {
    logic [1:0]       kind;
    logic [CharW-1:0] ch;
    logic [CharW-1:0] repl;
    logic             has_repl;
    logic             last;
    int               gap;    // idle cycles before offering this request
    bit               drain;  // hold until every pending result has come back
  } xlat_req_t;

  typedef struct {
    logic [CharW-1:0] out_char;
    logic             kept;
    logic             last;
  } xlat_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       req_type_i = REQ_CLEAR;
  logic [CharW-1:0] char_in_i = '0;
  logic [CharW-1:0] replacement_i = '0;
  logic             has_replacement_i = 1'b0;
  logic             last_in_i = 1'b0;
  logic             done_o;
  logic [CharW-1:0] out_char_o;
  logic             kept_o;
  logic             last_out_o;

  byte_translate_map DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .char_in_i         (char_in_i),
    .replacement_i     (replacement_i),
    .has_replacement_i (has_replacement_i),
    .last_in_i         (last_in_i),
    .done_o            (done_o),
    .out_char_o        (out_char_o),
    .kept_o            (kept_o),
    .last_out_o        (last_out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Requests waiting to be offered, and translations waiting to come back.
  xlat_req_t req_queue[$];
  xlat_res_t xlat_due[$];

  // Local copy of the translation table: a set flag per byte, and the action
  // (keep flag over replacement byte) that was stored by the first mapping.
  bit               map_set [MapDepth];
  logic [ActW-1:0]  map_act [MapDepth];

  int  accepted_cnt = 0;
  int  head_seen    = -1;
  int  hold_left    = 0;
  int  stall_cnt    = 0;
  int  fail_cnt     = 0;
  int  decoded_cnt  = 0;
  int  gap_odds     = 0;   // 0 disables sender idling, else 1-in-N chance per request
  bit  drain_next   = 1'b0;
  bit  moved;
  xlat_res_t got;
  xlat_res_t want;

  // Update the table for one accepted request; queue a translation for text bytes.
  task automatic translate_req(input xlat_req_t r);
    xlat_res_t res;
    case (r.kind)
      REQ_CLEAR: begin
        foreach (map_set[i]) map_set[i] = 1'b0;
      end
      REQ_MAP: begin
        // First mapping for a byte wins; repeats are dropped.
        if (!map_set[r.ch]) begin
          map_set[r.ch] = 1'b1;
          map_act[r.ch] = {r.has_repl, r.repl};
        end
      end
      REQ_TEXT: begin
        res.out_char = r.ch;
        res.kept     = 1'b1;
        res.last     = r.last;
        if (map_set[r.ch]) begin
          if (map_act[r.ch][CharW]) begin
            res.out_char = map_act[r.ch][CharW-1:0];
          end else begin
            res.kept     = 1'b0;
            res.out_char = '0;
          end
        end
        xlat_due.push_back(res);
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  task automatic report_field(input string name, input int exp_v, input int got_v);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    fail_cnt++;
  endtask

  // Append one request; idling and the drain hold follow the current settings.
  task automatic add_req(input logic [1:0] kind, input logic [CharW-1:0] ch,
                         input logic [CharW-1:0] repl, input logic has_repl,
                         input logic last);
    xlat_req_t r;
    r.kind     = kind;
    r.ch       = ch;
    r.repl     = repl;
    r.has_repl = has_repl;
    r.last     = last;
    r.gap      = 0;
    if (gap_odds != 0 && decoded_cnt < TextTarget - QuietTail &&
        $urandom_range(0, gap_odds - 1) == 0) begin
      r.gap = $urandom_range(1, 11);
    end
    r.drain    = drain_next && (decoded_cnt < TextTarget - QuietTail);
    drain_next = 1'b0;
    req_queue.push_back(r);
    if (kind != REQ_UNUSED) decoded_cnt++;
  endtask

  // One well-formed translation: optional clear, a few mappings drawn from a
  // small alphabet so that repeats and hits are common, then a text string.
  task automatic add_translation();
    logic [CharW-1:0] alpha [6];
    int               n_map;
    int               n_text;
    logic [CharW-1:0] c;
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) != 0) begin
      add_req(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    end
    n_map = $urandom_range(0, 7);
    for (int i = 0; i < n_map; i++) begin
      add_req(REQ_MAP, alpha[$urandom_range(0, 5)], 8'($urandom_range(0, 255)),
              $urandom_range(0, 3) != 0, 1'($urandom));
    end
    n_text = $urandom_range(1, 12);
    for (int i = 0; i < n_text; i++) begin
      c = ($urandom_range(0, 9) < 7) ? alpha[$urandom_range(0, 5)] : 8'($urandom_range(0, 255));
      add_req(REQ_TEXT, c, 8'($urandom), 1'($urandom), i == n_text - 1);
    end
  endtask

  // Noise: any request code with any field values, text with a random last marker.
  task automatic add_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      add_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'($urandom),
              1'($urandom));
    end
  endtask

  // Sender: present the head request at the falling edge; hold off for its idle
  // gap and, where flagged, until every translation in flight has come back.
  always @(negedge clk_i) begin
    if (!rst_ni || req_queue.size() == 0) begin
      start <= 1'b0;
    end else begin
      if (head_seen != accepted_cnt) begin
        head_seen = accepted_cnt;
        hold_left = req_queue[0].gap;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        start <= 1'b0;
      end else if (req_queue[0].drain && xlat_due.size() != 0) begin
        start <= 1'b0;
      end else begin
        start             <= 1'b1;
        req_type_i        <= req_queue[0].kind;
        char_in_i         <= req_queue[0].ch;
        replacement_i     <= req_queue[0].repl;
        has_replacement_i <= req_queue[0].has_repl;
        last_in_i         <= req_queue[0].last;
      end
    end
  end

  // Monitor: check the result strobe against the oldest expectation, then
  // advance the prediction for a request accepted at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        moved        = 1'b1;
        got.out_char = out_char_o;
        got.kept     = kept_o;
        got.last     = last_out_o;
        if (xlat_due.size() == 0) begin
          $display("%0t ns: result with none expected, actual char %0h kept %0b last %0b",
                   $time, got.out_char, got.kept, got.last);
          fail_cnt++;
        end else begin
          want = xlat_due.pop_front();
          if (got.out_char !== want.out_char) begin
            report_field("out_char", int'(want.out_char), int'(got.out_char));
          end
          if (got.kept !== want.kept) begin
            report_field("kept", int'(want.kept), int'(got.kept));
          end
          if (got.last !== want.last) begin
            report_field("last_out", int'(want.last), int'(got.last));
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        translate_req(req_queue.pop_front());
        accepted_cnt++;
      end
      stall_cnt = moved ? 0 : stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("%0t ns: no transfer for %0d cycles", $time, StallLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    // Directed part: identity after reset, unused code, replacement zero,
    // deletion, repeated from bytes, text byte zero and the byte extremes.
    add_req(REQ_TEXT,   8'h00, 8'h00, 1'b0, 1'b0);
    add_req(REQ_TEXT,   8'hFF, 8'hFF, 1'b1, 1'b1);
    add_req(REQ_UNUSED, 8'h42, 8'hFF, 1'b1, 1'b1);
    add_req(REQ_CLEAR,  8'hFF, 8'hFF, 1'b1, 1'b1);
    add_req(REQ_MAP,    8'h41, 8'h00, 1'b1, 1'b0);
    add_req(REQ_MAP,    8'h41, 8'h5A, 1'b1, 1'b0);
    add_req(REQ_MAP,    8'h00, 8'hFF, 1'b1, 1'b0);
    add_req(REQ_MAP,    8'hFF, 8'hAA, 1'b0, 1'b1);
    add_req(REQ_MAP,    8'h7F, 8'h00, 1'b0, 1'b0);
    add_req(REQ_MAP,    8'h7F, 8'h33, 1'b1, 1'b0);
    add_req(REQ_TEXT,   8'h41, 8'h00, 1'b0, 1'b0);
    add_req(REQ_TEXT,   8'h00, 8'h00, 1'b0, 1'b0);
    add_req(REQ_TEXT,   8'hFF, 8'h00, 1'b0, 1'b0);
    add_req(REQ_TEXT,   8'h7F, 8'h00, 1'b0, 1'b0);
    add_req(REQ_TEXT,   8'h42, 8'h00, 1'b0, 1'b1);
    add_req(REQ_UNUSED, 8'h42, 8'h99, 1'b1, 1'b0);
    add_req(REQ_TEXT,   8'h42, 8'h00, 1'b0, 1'b1);
    // Drain everything in flight before the clear, then map and read back
    // the same byte on consecutive cycles.
    drain_next = 1'b1;
    add_req(REQ_CLEAR,  8'h00, 8'h00, 1'b0, 1'b0);
    add_req(REQ_TEXT,   8'h41, 8'h00, 1'b0, 1'b0);
    add_req(REQ_MAP,    8'h80, 8'h01, 1'b1, 1'b0);
    add_req(REQ_TEXT,   8'h80, 8'h00, 1'b0, 1'b1);

    // Random part: mostly well-formed translations, some noise; idling is
    // switched on and off per burst and dropped for the tail.
    while (decoded_cnt < TextTarget) begin
      gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      drain_next = ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 9) == 0) add_noise();
      else add_translation();
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || xlat_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/btm_pkg.sv
rtl/core/btm_front.sv
rtl/core/btm_queue.sv
rtl/core/btm_back.sv
rtl/core/byte_translate_map.sv
rtl/core/btm_checker.sv
dv/byte_translate_map_tb.sv
